// ----- src/pgta_pkg.sv -----
// Shared constants, types and register codes of the paired gauge thickness averager.
package pgta_pkg;

	// Block dimensions
	localparam int CHANNELS   = 5;
	localparam int MAX_WINDOW = 64;
	localparam int NUM_BASE   = 5;

	// Field widths
	localparam int CH_W   = 3;
	localparam int DIST_W = 20;
	localparam int BASE_W = 21;
	localparam int OFS_W  = 21;
	localparam int WLEN_W = 7;
	localparam int CUR_W  = 23;
	localparam int AVG_W  = 22;

	// Derived widths of the per-channel ring state
	localparam int WP_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W     = AVG_W + CNT_W;
	localparam int DCNT_W    = $clog2(SUM_W);
	localparam int MEM_DEPTH = CHANNELS * MAX_WINDOW;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// Front to back queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration port
	localparam int APB_DW  = 32;
	localparam int PADDR_W = 5;
	localparam int REGI_W  = PADDR_W - 2;

	localparam logic [REGI_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [REGI_W-1:0] REG_WLEN      = 3'd1;
	localparam logic [REGI_W-1:0] REG_OFFSET    = 3'd2;
	localparam logic [REGI_W-1:0] REG_BASE0     = 3'd3;
	localparam logic [REGI_W-1:0] REG_BASE_LAST = 3'd7;

	localparam logic [NUM_BASE-1:0] ENABLE_RST = 5'd31;
	localparam logic [WLEN_W-1:0]   WLEN_RST   = 7'd16;

	typedef logic [NUM_BASE-1:0][BASE_W-1:0] base_arr_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [NUM_BASE-1:0]     enable;
		logic [WLEN_W-1:0]       window_len;
		logic signed [OFS_W-1:0] offset;
		base_arr_t               base;
	} pgta_cfg_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic [CH_W-1:0]         ch;
		logic signed [CUR_W-1:0] cur;
		logic                    en;
		logic                    fault;
	} pgta_item_t;

	// Finished result
	typedef struct packed {
		logic [CH_W-1:0]         ch;
		logic [AVG_W-1:0]        avg;
		logic signed [CUR_W-1:0] cur;
		logic                    off;
		logic                    fault;
	} pgta_res_t;

endpackage

// ----- src/paired_gauge_thickness_averager_top.sv -----
// Top level of the paired gauge thickness averager: configuration registers and stream ports.
//
// Input stream (s_*): one request per reading pair of a channel. Requests for a channel
// number at or above the channel count are taken and dropped without a result.
// Output stream (m_*): one result per kept request, in order: channel, moving average of
// the positive thicknesses in the channel's window, the thickness just stored, and the
// channel-off and sensor-fault flags in m_tuser.
// Configuration (APB): enable mask, window length, offset and five calibration bases at
// byte addresses 0x00 to 0x1C. Writing the window length empties every channel's window.
// The user must write the registers only while the block is idle; the block does not enforce it.
// An average is formed in the bit-serial divider of the back end; a disabled channel or
// one with no positive thickness in its window skips the divider. The back end takes the
// next request from the queue only after the last result is in the output register.
// The front end keeps taking requests into a two-entry queue while the back end divides
// or while a result waits in the output register; a stalled receiver fills the queue and
// then holds s_tready low.
// Reset clears the registers to their defaults, the windows to empty, and all handshakes.
module paired_gauge_thickness_averager_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [pgta_pkg::PADDR_W-1:0] paddr,
	input  logic [pgta_pkg::APB_DW-1:0]  pwdata,
	output logic [pgta_pkg::APB_DW-1:0]  prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] channel, [22:3] top_distance, [42:23] bottom_distance, [47:43] zero
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] out_channel, [24:3] average_um, [47:25] current_um
	output logic [47:0] m_tdata,
	// [0] channel_off, [1] sensor_fault
	output logic [1:0]  m_tuser
);
	import pgta_pkg::*;

	pgta_cfg_t         cfg_q;
	logic              wr_en;
	logic [REGI_W-1:0] idx;
	logic              clr;

	logic       push;
	logic       push_ready;
	pgta_item_t push_item;
	logic       head_valid;
	logic       pop;
	pgta_item_t head_item;
	pgta_res_t  res;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign clr    = wr_en && (idx == REG_WLEN);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable     <= ENABLE_RST;
			cfg_q.window_len <= WLEN_RST;
			cfg_q.offset     <= '0;
			cfg_q.base       <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_ENABLE: cfg_q.enable     <= pwdata[NUM_BASE-1:0];
				REG_WLEN:   cfg_q.window_len <= pwdata[WLEN_W-1:0];
				REG_OFFSET: cfg_q.offset     <= $signed(pwdata[OFS_W-1:0]);
				default: begin
					if (idx inside {[REG_BASE0:REG_BASE_LAST]}) begin
						cfg_q.base[idx - REG_BASE0] <= pwdata[BASE_W-1:0];
					end
				end
			endcase
		end
	end

	// Register reads
	always_comb begin
		prdata = '0;
		case (idx)
			REG_ENABLE: prdata = APB_DW'(cfg_q.enable);
			REG_WLEN:   prdata = APB_DW'(cfg_q.window_len);
			REG_OFFSET: prdata = APB_DW'($unsigned(cfg_q.offset));
			default: begin
				if (idx inside {[REG_BASE0:REG_BASE_LAST]}) begin
					prdata = APB_DW'(cfg_q.base[idx - REG_BASE0]);
				end
			end
		endcase
	end

	pgta_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_ch      (s_tdata[2:0]),
		.in_top     (s_tdata[22:3]),
		.in_bot     (s_tdata[42:23]),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	pgta_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item),
		.head_valid (head_valid),
		.pop        (pop),
		.head_item  (head_item)
	);

	pgta_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.window_len (cfg_q.window_len),
		.clr        (clr),
		.head_valid (head_valid),
		.pop        (pop),
		.head_item  (head_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res)
	);

	// Result packing
	assign m_tdata = {res.cur, res.avg, res.ch};
	assign m_tuser = {res.fault, res.off};

endmodule

// ----- src/pgta_front.sv -----
// Front end: accepts readings, drops unknown channels, forms the thickness value.
module pgta_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pgta_pkg::pgta_cfg_t   cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [pgta_pkg::CH_W-1:0]   in_ch,
	input  logic [pgta_pkg::DIST_W-1:0] in_top,
	input  logic [pgta_pkg::DIST_W-1:0] in_bot,
	output logic                  push,
	input  logic                  push_ready,
	output pgta_pkg::pgta_item_t  push_item
);
	import pgta_pkg::*;

	logic                    valid_s1;
	logic [CH_W-1:0]         ch_s1;
	logic signed [CUR_W-1:0] diff_s1;
	logic [DIST_W-1:0]       bot_s1;
	logic                    en_s1;
	logic                    fault_s1;

	logic                    accept;
	logic                    in_range;
	logic                    en;
	logic [BASE_W-1:0]       base_sel;
	logic signed [CUR_W-1:0] raw;
	logic signed [CUR_W-1:0] ofs_ext;

	// Handshake
	assign in_ready = !valid_s1 || push_ready;
	assign accept   = in_valid && in_ready;
	assign in_range = (int'(in_ch) < CHANNELS);
	assign push     = valid_s1;

	// Channel lookup
	always_comb begin
		en       = 1'b0;
		base_sel = '0;
		if (int'(in_ch) < NUM_BASE) begin
			en       = cfg.enable[in_ch];
			base_sel = cfg.base[in_ch];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && in_range) begin
			valid_s1 <= 1'b1;
		end else if (push && push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// First half of the subtraction
	always_ff @(posedge clk) begin
		if (accept && in_range) begin
			ch_s1    <= in_ch;
			diff_s1  <= $signed({{(CUR_W-BASE_W){1'b0}}, base_sel})
				- $signed({{(CUR_W-DIST_W){1'b0}}, in_top});
			bot_s1   <= in_bot;
			en_s1    <= en;
			fault_s1 <= en && ((in_top == '0) || (in_bot == '0));
		end
	end

	// Second half, offset applied only to a nonzero thickness
	assign raw     = diff_s1 - $signed({{(CUR_W-DIST_W){1'b0}}, bot_s1});
	assign ofs_ext = CUR_W'(cfg.offset);

	always_comb begin
		push_item.ch    = ch_s1;
		push_item.en    = en_s1;
		push_item.fault = fault_s1;
		if (!en_s1) begin
			push_item.cur = '1;
		end else if (fault_s1 || (raw == '0)) begin
			push_item.cur = '0;
		end else begin
			push_item.cur = raw + ofs_ext;
		end
	end

endmodule

// ----- src/pgta_queue.sv -----
// Short FIFO that decouples the front end from the averaging back end.
module pgta_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 push_ready,
	input  pgta_pkg::pgta_item_t push_item,
	output logic                 head_valid,
	input  logic                 pop,
	output pgta_pkg::pgta_item_t head_item
);
	import pgta_pkg::*;

	pgta_item_t        slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (int'(cnt_q) < QDEPTH);
	assign head_valid = (cnt_q != '0);
	assign head_item  = slot_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (int'(wr_q) == QDEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (int'(rd_q) == QDEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

// ----- src/pgta_back.sv -----
// Back end: ring update per channel, positive sum tracking, serial divide, result register.
module pgta_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [pgta_pkg::WLEN_W-1:0] window_len,
	input  logic                  clr,
	input  logic                  head_valid,
	output logic                  pop,
	input  pgta_pkg::pgta_item_t  head_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pgta_pkg::pgta_res_t   out_res
);
	import pgta_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;

	// Per-channel ring state
	logic [WP_W-1:0]  wp_q   [CHANNELS];
	logic [CNT_W-1:0] fill_q [CHANNELS];
	logic [SUM_W-1:0] sum_q  [CHANNELS];
	logic [CNT_W-1:0] pcnt_q [CHANNELS];

	// Window memory
	logic signed [CUR_W-1:0] mem [MEM_DEPTH];
	logic signed [CUR_W-1:0] rdata_q;

	// Item and divider registers
	pgta_item_t        item_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              out_valid_q;
	pgta_res_t         out_q;

	logic [CNT_W-1:0]  eff_len;
	logic [WP_W-1:0]   wp_eff;
	logic [WP_W-1:0]   wp_next;
	logic [ADDR_W-1:0] addr;
	logic              evict;
	logic              old_pos;
	logic              cur_pos;
	logic [SUM_W-1:0]  sum_new;
	logic [CNT_W-1:0]  cnt_new;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_dif;
	logic              q_bit;
	logic              load_out;

	// Effective window length, clamped to 1..MAX_WINDOW
	always_comb begin
		if (window_len == '0) begin
			eff_len = CNT_W'(1);
		end else if (int'(window_len) > MAX_WINDOW) begin
			eff_len = CNT_W'(MAX_WINDOW);
		end else begin
			eff_len = CNT_W'(window_len);
		end
	end

	// Ring slot and running totals for the current item
	always_comb begin
		wp_eff  = (CNT_W'(wp_q[item_q.ch]) >= eff_len) ? '0 : wp_q[item_q.ch];
		wp_next = ((CNT_W'(wp_eff) + 1'b1) >= eff_len) ? '0 : wp_eff + 1'b1;
		addr    = ADDR_W'(item_q.ch) * ADDR_W'(MAX_WINDOW) + ADDR_W'(wp_eff);
		evict   = fill_q[item_q.ch] >= eff_len;
		old_pos = evict && !rdata_q[CUR_W-1] && (rdata_q != '0);
		cur_pos = !item_q.cur[CUR_W-1] && (item_q.cur != '0);
		sum_new = sum_q[item_q.ch]
			+ (cur_pos ? SUM_W'($unsigned(item_q.cur)) : '0)
			- (old_pos ? SUM_W'($unsigned(rdata_q)) : '0);
		cnt_new = pcnt_q[item_q.ch]
			+ (cur_pos ? CNT_W'(1) : '0)
			- (old_pos ? CNT_W'(1) : '0);
	end

	// Restoring divide step
	assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
	assign q_bit   = rem_sh >= {1'b0, div_q};
	assign rem_dif = rem_sh - {1'b0, div_q};

	assign pop       = (state_q == ST_IDLE) && head_valid;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
				sum_q[i]  <= '0;
				pcnt_q[i] <= '0;
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (clr) begin
				for (int i = 0; i < CHANNELS; i++) begin
					wp_q[i]   <= '0;
					fill_q[i] <= '0;
					sum_q[i]  <= '0;
					pcnt_q[i] <= '0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					wp_q[item_q.ch]   <= wp_next;
					fill_q[item_q.ch] <= evict ? fill_q[item_q.ch] : fill_q[item_q.ch] + 1'b1;
					sum_q[item_q.ch]  <= sum_new;
					pcnt_q[item_q.ch] <= cnt_new;
					if (item_q.en && (cnt_new != '0)) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (dcnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Window memory access
	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			rdata_q <= mem[addr];
		end
		if (state_q == ST_UPD) begin
			mem[addr] <= item_q.cur;
		end
	end

	// Item capture, divider datapath and result register
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head_item;
		end
		if (state_q == ST_UPD) begin
			quo_q  <= (item_q.en && (cnt_new != '0)) ? sum_new : '0;
			div_q  <= cnt_new;
			rem_q  <= '0;
			dcnt_q <= DCNT_W'(SUM_W - 1);
		end else if (state_q == ST_DIV) begin
			rem_q  <= q_bit ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], q_bit};
			dcnt_q <= dcnt_q - 1'b1;
		end
		if (load_out) begin
			out_q.ch    <= item_q.ch;
			out_q.avg   <= quo_q[AVG_W-1:0];
			out_q.cur   <= item_q.cur;
			out_q.off   <= !item_q.en;
			out_q.fault <= item_q.fault;
		end
	end

endmodule

// ----- test/pgta_checker.sv -----
// Result checker of the paired gauge thickness averager: tracks the registers, predicts and compares.
module pgta_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pgta_pkg::PADDR_W-1:0] paddr,
	input  logic [pgta_pkg::APB_DW-1:0]  pwdata,
	input  logic                         pready,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [47:0]                  s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [47:0]                  m_tdata,
	input  logic [1:0]                   m_tuser,
	output int                           errors,
	output int                           outstanding
);
	import pgta_pkg::*;

	localparam int EXP_DEPTH = 64;

	// Register copy
	logic [NUM_BASE-1:0]     enable_mask;
	logic [WLEN_W-1:0]       window_len;
	logic signed [OFS_W-1:0] offset_um;
	logic [BASE_W-1:0]       cal_base [NUM_BASE];

	// Per-channel thickness rings
	logic signed [CUR_W-1:0] ring [CHANNELS][MAX_WINDOW];
	int unsigned             ring_wp [CHANNELS];
	int unsigned             ring_fill [CHANNELS];
	int unsigned             pos_count [CHANNELS];
	longint unsigned         pos_sum [CHANNELS];

	// Expected results in arrival order
	pgta_res_t expected_results [EXP_DEPTH];
	int        exp_wr;
	int        exp_rd;
	int        exp_level;
	int        mismatch_count;

	function automatic void empty_rings();
		for (int c = 0; c < CHANNELS; c++) begin
			for (int k = 0; k < MAX_WINDOW; k++)
				ring[c][k] = '0;
			ring_wp[c] = 0;
			ring_fill[c] = 0;
			pos_count[c] = 0;
			pos_sum[c] = 0;
		end
	endfunction

	function automatic void apply_reg_write(logic [PADDR_W-1:0] addr, logic [APB_DW-1:0] data);
		logic [REGI_W-1:0] idx;
		idx = addr[PADDR_W-1:2];
		if (idx == REG_ENABLE) begin
			enable_mask = data[NUM_BASE-1:0];
		end else if (idx == REG_WLEN) begin
			window_len = data[WLEN_W-1:0];
			empty_rings();
		end else if (idx == REG_OFFSET) begin
			offset_um = data[OFS_W-1:0];
		end else if (idx >= REG_BASE0 && idx <= REG_BASE_LAST) begin
			cal_base[idx - REG_BASE0] = data[BASE_W-1:0];
		end
	endfunction

	// Thickness, ring update and average for one reading pair
	function automatic void predict_reading(logic [47:0] req);
		logic [CH_W-1:0]         ch;
		logic [DIST_W-1:0]       top_d;
		logic [DIST_W-1:0]       bot_d;
		logic signed [CUR_W-1:0] cur;
		logic signed [CUR_W-1:0] old;
		logic                    on;
		logic                    flt;
		int                      thick;
		int unsigned             len;
		int unsigned             slot;
		longint unsigned         quot;
		pgta_res_t               res;
		ch = req[2:0];
		top_d = req[22:3];
		bot_d = req[42:23];
		if (ch >= CHANNELS)
			return;
		on = (ch < NUM_BASE) ? enable_mask[ch] : 1'b0;
		flt = 1'b0;
		if (!on) begin
			cur = '1;
		end else if (top_d == 0 || bot_d == 0) begin
			cur = '0;
			flt = 1'b1;
		end else begin
			thick = int'(cal_base[ch]) - int'(top_d) - int'(bot_d);
			// offset only applies to a nonzero raw thickness
			if (thick != 0)
				thick += offset_um;
			cur = thick[CUR_W-1:0];
		end

		// window length 0 acts as 1, anything above the ring size as the ring size
		len = (window_len == 0) ? 1 : (window_len > MAX_WINDOW) ? MAX_WINDOW : window_len;
		slot = ring_wp[ch];
		if (slot >= len)
			slot = 0;
		if (ring_fill[ch] >= len) begin
			old = ring[ch][slot];
			if (old > 0) begin
				pos_sum[ch] -= longint'(old);
				pos_count[ch]--;
			end
		end else begin
			ring_fill[ch]++;
		end
		ring[ch][slot] = cur;
		if (cur > 0) begin
			pos_sum[ch] += longint'(cur);
			pos_count[ch]++;
		end
		slot++;
		if (slot >= len)
			slot = 0;
		ring_wp[ch] = slot;

		quot = 0;
		if (on && pos_count[ch] != 0)
			quot = pos_sum[ch] / pos_count[ch];
		res.ch = ch;
		res.avg = quot[AVG_W-1:0];
		res.cur = cur;
		res.off = !on;
		res.fault = flt;
		if (exp_level == EXP_DEPTH) begin
			$error("expected result store overflow: channel %0d", ch);
			mismatch_count++;
			return;
		end
		expected_results[exp_wr] = res;
		exp_wr = (exp_wr == EXP_DEPTH - 1) ? 0 : exp_wr + 1;
		exp_level++;
	endfunction

	function automatic void check_result();
		pgta_res_t exp_r;
		if (exp_level == 0) begin
			$error("unexpected result: channel %0d", m_tdata[2:0]);
			mismatch_count++;
			return;
		end
		exp_r = expected_results[exp_rd];
		exp_rd = (exp_rd == EXP_DEPTH - 1) ? 0 : exp_rd + 1;
		exp_level--;
		if (m_tdata[2:0] !== exp_r.ch) begin
			$error("out_channel: expected %0d, actual %0d", exp_r.ch, m_tdata[2:0]);
			mismatch_count++;
		end
		if (m_tdata[24:3] !== exp_r.avg) begin
			$error("average_um: expected %0d, actual %0d", exp_r.avg, m_tdata[24:3]);
			mismatch_count++;
		end
		if (m_tdata[47:25] !== exp_r.cur) begin
			$error("current_um: expected %0d, actual %0d", exp_r.cur,
				$signed(m_tdata[47:25]));
			mismatch_count++;
		end
		if (m_tuser[0] !== exp_r.off) begin
			$error("channel_off: expected %0d, actual %0d", exp_r.off, m_tuser[0]);
			mismatch_count++;
		end
		if (m_tuser[1] !== exp_r.fault) begin
			$error("sensor_fault: expected %0d, actual %0d", exp_r.fault, m_tuser[1]);
			mismatch_count++;
		end
	endfunction

	// Watch the register port and both streams at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask = ENABLE_RST;
			window_len = WLEN_RST;
			offset_um = '0;
			for (int b = 0; b < NUM_BASE; b++)
				cal_base[b] = '0;
			empty_rings();
			exp_wr = 0;
			exp_rd = 0;
			exp_level = 0;
			mismatch_count = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (psel && penable && pwrite && pready)
				apply_reg_write(paddr, pwdata);
			if (s_tvalid && s_tready)
				predict_reading(s_tdata);
		end
		errors <= mismatch_count;
		outstanding <= exp_level;
	end

endmodule

// ----- test/tb_paired_gauge_thickness_averager_top.sv -----
// Stimulus and verdict for the paired gauge thickness averager top level.
module tb_paired_gauge_thickness_averager_top;
	import pgta_pkg::*;

	localparam int SETTLE_CYCLES = 48;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 10;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               s_tvalid;
	logic               s_tready;
	logic [47:0]        s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [47:0]        m_tdata;
	logic [1:0]         m_tuser;

	int errors;
	int outstanding;
	int cycle_count = 0;

	// Traffic shaping
	bit sender_steady = 1'b0;
	bit sink_steady   = 1'b0;
	int burst_left    = 0;
	int hold_left     = 0;
	bit hold_ready;

	logic [BASE_W-1:0] cal_base [NUM_BASE];

	paired_gauge_thickness_averager_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	pgta_checker thickness_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .outstanding(outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL paired_gauge_thickness_averager_top");
			$finish;
		end
	end

	// Receiver: always ready in steady phases, else runs of ready and stall of random length
	always @(negedge clk) begin
		if (sink_steady) begin
			m_tready <= 1'b1;
		end else if (hold_left == 0) begin
			hold_ready = ($urandom_range(0, 2) != 0);
			hold_left = hold_ready ? $urandom_range(1, 20) : $urandom_range(1, 24);
			m_tready <= hold_ready;
		end else begin
			hold_left--;
		end
	end

	task automatic write_reg(input logic [REGI_W-1:0] idx, input logic [APB_DW-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One reading pair request, with burst gaps in front unless the sender is steady
	task automatic send_reading(input logic [CH_W-1:0] ch, input logic [DIST_W-1:0] top_d,
			input logic [DIST_W-1:0] bot_d);
		int gap;
		if (!sender_steady && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, bot_d, top_d, ch};
		if (burst_left > 0)
			burst_left--;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and let every result come out before touching registers
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input int ch, input logic [BASE_W-1:0] val);
		cal_base[ch] = val;
		write_reg(REG_BASE0 + REGI_W'(ch), APB_DW'(val));
	endtask

	// Mostly readings that fit inside the base, some missing, some arbitrary
	function automatic void pick_readings(input logic [BASE_W-1:0] base,
			output logic [DIST_W-1:0] top_d, output logic [DIST_W-1:0] bot_d);
		int kind;
		kind = $urandom_range(0, 19);
		top_d = DIST_W'($urandom_range(0, 20'hFFFFF));
		bot_d = DIST_W'($urandom_range(0, 20'hFFFFF));
		if (kind == 0) begin
			top_d = '0;
		end else if (kind == 1) begin
			bot_d = '0;
		end else if (kind > 4 && base >= 2) begin
			top_d = DIST_W'($urandom_range(1, base / 2));
			bot_d = DIST_W'($urandom_range(1, base / 2));
		end
	endfunction

	initial begin
		int phase_wlen [PHASES]  = '{8, 64, 1, 3, 0, 127, 16, 2, 5, 64};
		bit phase_newlen [PHASES] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 0};
		int phase_items [PHASES] = '{70, 200, 60, 70, 50, 90, 90, 60, 80, 80};
		int focus;
		int pick;
		int ofs;
		logic [CH_W-1:0]   ch;
		logic [DIST_W-1:0] top_d;
		logic [DIST_W-1:0] bot_d;
		logic [BASE_W-1:0] base;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		for (int b = 0; b < NUM_BASE; b++)
			cal_base[b] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: zero base gives negative thickness
		send_reading(3'd0, 20'd1, 20'd1);
		send_reading(3'd3, 20'd0, 20'd7);
		drain_results();

		// Base extremes, window of four
		write_reg(REG_ENABLE, 32'd31);
		write_reg(REG_WLEN, 32'd4);
		write_reg(REG_OFFSET, 32'd0);
		write_base(0, 21'h1FFFFF);
		write_base(1, 21'd0);
		write_base(2, 21'd1000000);
		write_base(3, 21'd300000);
		write_base(4, 21'd1500000);
		send_reading(3'd0, 20'd1, 20'd1);
		send_reading(3'd0, 20'hFFFFF, 20'hFFFFF);
		send_reading(3'd0, 20'd0, 20'd5);
		send_reading(3'd0, 20'd5, 20'd0);
		send_reading(3'd0, 20'd0, 20'd0);
		send_reading(3'd0, 20'd1000, 20'd1000);
		send_reading(3'd1, 20'hFFFFF, 20'hFFFFF);
		send_reading(3'd2, 20'd500000, 20'd500000);
		send_reading(3'd5, 20'd100, 20'd100);
		send_reading(3'd7, 20'hFFFFF, 20'd0);
		drain_results();

		// Disabled channels, most negative offset, single-entry window
		write_reg(REG_ENABLE, 32'b10101);
		write_reg(REG_OFFSET, 32'(-1048576));
		write_reg(REG_WLEN, 32'd1);
		send_reading(3'd1, 20'd0, 20'd3);
		send_reading(3'd3, 20'd10, 20'd10);
		send_reading(3'd2, 20'd500000, 20'd500000);
		send_reading(3'd2, 20'd1, 20'd1);
		send_reading(3'd4, 20'd100, 20'd100);
		send_reading(3'd4, 20'd200, 20'd100);
		drain_results();

		// Largest offset, window length zero, all channels off
		write_reg(REG_OFFSET, 32'd1048575);
		write_reg(REG_WLEN, 32'd0);
		send_reading(3'd2, 20'd1, 20'd1);
		send_reading(3'd4, 20'd1, 20'd2);
		send_reading(3'd4, 20'd3, 20'd2);
		drain_results();
		write_reg(REG_ENABLE, 32'd0);
		send_reading(3'd0, 20'd9, 20'd9);
		send_reading(3'd6, 20'd9, 20'd9);
		drain_results();

		// Random phases, each with its own register setting
		for (int p = 0; p < PHASES; p++) begin
			sender_steady = (p % 3 == 0);
			sink_steady = (p % 4 == 1);
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_ENABLE, 32'd31);
			else
				write_reg(REG_ENABLE, $urandom_range(0, 31));
			pick = $urandom_range(0, 2);
			if (pick == 0)
				ofs = 0;
			else if (pick == 1)
				ofs = $urandom_range(0, 4000) - 2000;
			else
				ofs = $urandom_range(0, 2097151) - 1048576;
			write_reg(REG_OFFSET, 32'(ofs));
			for (int b = 0; b < NUM_BASE; b++) begin
				if ($urandom_range(0, 3) == 0)
					write_base(b, BASE_W'($urandom_range(0, 21'h1FFFFF)));
				else
					write_base(b, BASE_W'($urandom_range(200000, 21'h1FFFFF)));
			end
			if (phase_newlen[p])
				write_reg(REG_WLEN, phase_wlen[p]);
			focus = $urandom_range(0, CHANNELS - 1);

			for (int i = 0; i < phase_items[p]; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 4)
					ch = CH_W'($urandom_range(CHANNELS, 7));
				else if (pick < 64)
					ch = CH_W'(focus);
				else
					ch = CH_W'($urandom_range(0, CHANNELS - 1));
				base = (ch < NUM_BASE) ? cal_base[ch]
					: BASE_W'($urandom_range(0, 21'h1FFFFF));
				pick_readings(base, top_d, bot_d);
				send_reading(ch, top_d, bot_d);
			end
			drain_results();
		end

		if (errors == 0 && outstanding == 0)
			$display("PASS paired_gauge_thickness_averager_top");
		else
			$display("FAIL paired_gauge_thickness_averager_top");
		$finish;
	end

endmodule

// ----- paired_gauge_thickness_averager_top.f -----
src/pgta_pkg.sv
src/pgta_front.sv
src/pgta_queue.sv
src/pgta_back.sv
src/paired_gauge_thickness_averager_top.sv
test/pgta_checker.sv
test/tb_paired_gauge_thickness_averager_top.sv
